// ===== rtl/core/rtpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpm_pkg
// Shared types and constants of the rotated target point mapper.
// ----------------------------------------------------------------------------
package rtpm_pkg;

    localparam int REL_W  = 16;
    localparam int OUT_W  = 25;
    localparam int CIDX_W = 4;
    localparam int CDAT_W = 16;
    localparam int MX_W   = 44;
    localparam int MY_W   = 70;
    localparam int DX_W   = 16;
    localparam int DY_W   = 41;

    typedef enum logic [CIDX_W-1:0] {
        CFG_C0X   = 4'd0,
        CFG_C0Y   = 4'd1,
        CFG_C1X   = 4'd2,
        CFG_C1Y   = 4'd3,
        CFG_SCALE = 4'd4,
        CFG_W     = 4'd5,
        CFG_H     = 4'd6,
        CFG_UD    = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] c0x;
        logic [15:0] c0y;
        logic [15:0] c1x;
        logic [15:0] c1y;
        logic [8:0]  scale;
        logic [15:0] w;
        logic [15:0] h;
        logic        ud;
    } t_cfg;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_div_tag;

endpackage

// ===== rtl/core/rtpm_if.sv =====
// ----------------------------------------------------------------------------
// rtpm_if
// Channel interfaces: patch input, pixel output and register write.
// ----------------------------------------------------------------------------
interface rtpm_pt_if;
    import rtpm_pkg::*;
    logic             valid;
    logic             ready;
    logic [REL_W-1:0] rel_x;
    logic [REL_W-1:0] rel_x_mirror;
    logic [REL_W-1:0] rel_y;
    modport source (output valid, rel_x, rel_x_mirror, rel_y, input ready);
    modport sink (input valid, rel_x, rel_x_mirror, rel_y, output ready);
endinterface

interface rtpm_px_if;
    import rtpm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] pixel_x;
    logic signed [OUT_W-1:0] pixel_y;
    logic                    degenerate;
    modport source (output valid, pixel_x, pixel_y, degenerate, input ready);
    modport sink (input valid, pixel_x, pixel_y, degenerate, output ready);
endinterface

interface rtpm_cfg_if;
    import rtpm_pkg::*;
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [CDAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rtpm_front.sv =====
// ----------------------------------------------------------------------------
// rtpm_front
// Eight-stage arithmetic pipeline forming both numerator magnitudes.
// ----------------------------------------------------------------------------
module rtpm_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rtpm_pkg::t_cfg         i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [15:0]            i_rel_x,
    input  logic [15:0]            i_rel_x_mirror,
    input  logic [15:0]            i_rel_y,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [43:0]            o_mx,
    output logic [69:0]            o_my,
    output logic [40:0]            o_deny,
    output rtpm_pkg::t_div_tag     o_tag_x,
    output rtpm_pkg::t_div_tag     o_tag_y
);
    import rtpm_pkg::*;

    logic [1:8] r_v;
    logic [1:9] en;
    logic [1:8] r_dg;

    assign en[9] = i_ready;
    assign o_ready = en[1];

    for (genvar k = 1; k <= 8; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_valid;
            for (int k = 2; k <= 8; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: edge vector and scaled corner, x sign folded into dy
    logic signed [16:0] n_s1_difx, n_s1_dify, n_s1_sdy;
    logic [16:0]        n_s1_adx;
    logic signed [9:0]  n_s1_scl;
    logic [25:0]        n_s1_axf;
    logic signed [26:0] n_s1_dyp;
    logic signed [25:0] n_s1_sx, n_s1_sy;
    logic [15:0]        n_s1_px;
    logic [16:0]        n_s1_yh;
    logic               n_s1_dg;
    logic [24:0]        r_s1_ax;
    logic signed [25:0] r_s1_sdy;
    logic signed [24:0] r_s1_sx, r_s1_sy;
    logic [15:0]        r_s1_px;
    logic [16:0]        r_s1_yh;

    always_comb begin
        n_s1_difx = $signed({i_cfg.c1x[15], i_cfg.c1x}) - $signed({i_cfg.c0x[15], i_cfg.c0x});
        n_s1_dify = $signed({i_cfg.c1y[15], i_cfg.c1y}) - $signed({i_cfg.c0y[15], i_cfg.c0y});
        n_s1_adx  = n_s1_difx[16] ? 17'(-n_s1_difx) : 17'(n_s1_difx);
        n_s1_sdy  = n_s1_difx[16] ? -n_s1_dify : n_s1_dify;
        n_s1_scl  = $signed({1'b0, i_cfg.scale});
        n_s1_axf  = n_s1_adx * i_cfg.scale;
        n_s1_dyp  = n_s1_sdy * n_s1_scl;
        n_s1_sx   = $signed(i_cfg.c0x) * n_s1_scl;
        n_s1_sy   = $signed(i_cfg.c0y) * n_s1_scl;
        n_s1_px   = i_cfg.ud ? i_rel_x_mirror : i_rel_x;
        n_s1_yh   = i_cfg.ud ? 17'h10000 - {1'b0, i_rel_y} : {1'b0, i_rel_y};
        n_s1_dg   = (n_s1_difx == '0) || (i_cfg.scale == '0) || (i_cfg.w == '0);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 2; k <= 8; k++) begin
            if (en[k]) r_dg[k] <= r_dg[k-1];
        end
        if (en[1]) r_dg[1] <= n_s1_dg;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_ax  <= n_s1_axf[24:0];
            r_s1_sdy <= n_s1_dyp[25:0];
            r_s1_sx  <= n_s1_sx[24:0];
            r_s1_sy  <= n_s1_sy[24:0];
            r_s1_px  <= n_s1_px;
            r_s1_yh  <= n_s1_yh;
        end
    end

    // stage 2: first products
    logic [40:0]        n_s2_a1;
    logic [32:0]        n_s2_b1;
    logic [49:0]        n_s2_axx;
    logic signed [51:0] n_s2_dyy;
    logic signed [41:0] n_s2_cxw, n_s2_cyw;
    logic [40:0]        r_s2_a1;
    logic [32:0]        r_s2_b1;
    logic [49:0]        r_s2_axx, r_s2_dyy;
    logic signed [40:0] r_s2_cxw, r_s2_cyw;
    logic [24:0]        r_s2_ax;
    logic signed [25:0] r_s2_sdy;

    always_comb begin
        n_s2_a1  = r_s1_px * r_s1_ax;
        n_s2_b1  = r_s1_yh * i_cfg.h;
        n_s2_axx = r_s1_ax * r_s1_ax;
        n_s2_dyy = r_s1_sdy * r_s1_sdy;
        n_s2_cxw = r_s1_sx * $signed({1'b0, i_cfg.w});
        n_s2_cyw = r_s1_sy * $signed({1'b0, i_cfg.w});
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_a1  <= n_s2_a1;
            r_s2_b1  <= n_s2_b1;
            r_s2_axx <= n_s2_axx;
            r_s2_dyy <= n_s2_dyy[49:0];
            r_s2_cxw <= n_s2_cxw[40:0];
            r_s2_cyw <= n_s2_cyw[40:0];
            r_s2_ax  <= r_s1_ax;
            r_s2_sdy <= r_s1_sdy;
        end
    end

    // stage 3: second products and edge length squared
    logic [56:0]        n_s3_t1;
    logic signed [59:0] n_s3_t2;
    logic [50:0]        n_s3_d;
    logic signed [66:0] n_s3_cyax;
    logic [40:0]        n_s3_deny;
    logic [56:0]        r_s3_t1;
    logic signed [59:0] r_s3_t2;
    logic [50:0]        r_s3_d;
    logic signed [65:0] r_s3_cyax;
    logic [40:0]        r_s3_deny;
    logic [32:0]        r_s3_b1;
    logic signed [25:0] r_s3_sdy;
    logic signed [40:0] r_s3_cxw;

    always_comb begin
        n_s3_t1   = r_s2_a1 * i_cfg.w;
        n_s3_t2   = $signed({1'b0, r_s2_b1}) * r_s2_sdy;
        n_s3_d    = {1'b0, r_s2_axx} + {1'b0, r_s2_dyy};
        n_s3_cyax = r_s2_cyw * $signed({1'b0, r_s2_ax});
        n_s3_deny = i_cfg.w * r_s2_ax;
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_t1   <= n_s3_t1;
            r_s3_t2   <= n_s3_t2;
            r_s3_d    <= n_s3_d;
            r_s3_cyax <= n_s3_cyax[65:0];
            r_s3_deny <= n_s3_deny;
            r_s3_b1   <= r_s2_b1;
            r_s3_sdy  <= r_s2_sdy;
            r_s3_cxw  <= r_s2_cxw;
        end
    end

    // stage 4: common term n and split product of yh*h by d
    logic signed [59:0] n_s4_n;
    logic [58:0]        n_s4_e1;
    logic [57:0]        n_s4_e2;
    logic signed [59:0] r_s4_n;
    logic [58:0]        r_s4_e1;
    logic [57:0]        r_s4_e2;
    logic signed [25:0] r_s4_sdy;
    logic signed [40:0] r_s4_cxw;
    logic signed [65:0] r_s4_cyax;
    logic [40:0]        r_s4_deny;

    always_comb begin
        n_s4_n  = $signed({3'b0, r_s3_t1}) - r_s3_t2;
        n_s4_e1 = r_s3_b1 * r_s3_d[25:0];
        n_s4_e2 = r_s3_b1 * r_s3_d[50:26];
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4_n    <= n_s4_n;
            r_s4_e1   <= n_s4_e1;
            r_s4_e2   <= n_s4_e2;
            r_s4_sdy  <= r_s3_sdy;
            r_s4_cxw  <= r_s3_cxw;
            r_s4_cyax <= r_s3_cyax;
            r_s4_deny <= r_s3_deny;
        end
    end

    // stage 5: x numerator, split product of n by dy
    logic signed [60:0] n_s5_numx;
    logic signed [56:0] n_s5_f1;
    logic signed [55:0] n_s5_f2;
    logic [83:0]        n_s5_e;
    logic signed [60:0] r_s5_numx;
    logic signed [56:0] r_s5_f1;
    logic signed [55:0] r_s5_f2;
    logic [83:0]        r_s5_e;
    logic signed [65:0] r_s5_cyax;
    logic [40:0]        r_s5_deny;

    always_comb begin
        n_s5_numx = r_s4_n + $signed({{4{r_s4_cxw[40]}}, r_s4_cxw, 16'd0});
        n_s5_f1   = $signed({1'b0, r_s4_n[29:0]}) * r_s4_sdy;
        n_s5_f2   = $signed(r_s4_n[59:30]) * r_s4_sdy;
        n_s5_e    = r_s4_e1 + {r_s4_e2, 26'd0};
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s5_numx <= n_s5_numx;
            r_s5_f1   <= n_s5_f1;
            r_s5_f2   <= n_s5_f2;
            r_s5_e    <= n_s5_e;
            r_s5_cyax <= r_s4_cyax;
            r_s5_deny <= r_s4_deny;
        end
    end

    // stage 6: partial sums of the y numerator
    logic signed [85:0] n_s6_nya, n_s6_nyb;
    logic signed [85:0] r_s6_nya, r_s6_nyb;
    logic signed [60:0] r_s6_numx;
    logic [40:0]        r_s6_deny;

    always_comb begin
        n_s6_nya = r_s5_f1 + $signed({r_s5_f2, 30'd0});
        n_s6_nyb = $signed({2'b0, r_s5_e}) + $signed({r_s5_cyax, 16'd0});
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s6_nya  <= n_s6_nya;
            r_s6_nyb  <= n_s6_nyb;
            r_s6_numx <= r_s5_numx;
            r_s6_deny <= r_s5_deny;
        end
    end

    // stage 7: y numerator
    logic signed [86:0] n_s7_ny;
    logic signed [86:0] r_s7_ny;
    logic signed [60:0] r_s7_numx;
    logic [40:0]        r_s7_deny;

    assign n_s7_ny = r_s6_nya + r_s6_nyb;

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_s7_ny   <= n_s7_ny;
            r_s7_numx <= r_s6_numx;
            r_s7_deny <= r_s6_deny;
        end
    end

    // stage 8: magnitudes, the common 2^16 factor of both divisors dropped
    logic [60:0] n_s8_magx;
    logic [86:0] n_s8_magy;
    logic [43:0] r_s8_mx;
    logic [69:0] r_s8_my;
    logic        r_s8_negx, r_s8_negy;
    logic [40:0] r_s8_deny;

    always_comb begin
        n_s8_magx = r_s7_numx[60] ? 61'(-r_s7_numx) : 61'(r_s7_numx);
        n_s8_magy = r_s7_ny[86] ? 87'(-r_s7_ny) : 87'(r_s7_ny);
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_s8_mx   <= n_s8_magx[59:16];
            r_s8_my   <= n_s8_magy[85:16];
            r_s8_negx <= r_s7_numx[60];
            r_s8_negy <= r_s7_ny[86];
            r_s8_deny <= r_s7_deny;
        end
    end

    assign o_valid      = r_v[8];
    assign o_mx         = r_s8_mx;
    assign o_my         = r_s8_my;
    assign o_deny       = r_s8_deny;
    assign o_tag_x.neg  = r_s8_negx;
    assign o_tag_x.zero = r_dg[8];
    assign o_tag_y.neg  = r_s8_negy;
    assign o_tag_y.zero = r_dg[8];

endmodule

// ===== rtl/core/rtpm_div.sv =====
// ----------------------------------------------------------------------------
// rtpm_div
// Pipelined restoring divider, one quotient bit per stage, with saturation
// of the signed result to the output range.
// ----------------------------------------------------------------------------
module rtpm_div #(
    parameter int MW = 44,
    parameter int DW = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [MW-1:0]             i_num,
    input  logic [DW-1:0]             i_den,
    input  rtpm_pkg::t_div_tag        i_tag,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [rtpm_pkg::OUT_W-1:0] o_quot,
    output rtpm_pkg::t_div_tag        o_tag
);
    import rtpm_pkg::*;

    localparam int QB = OUT_W;
    localparam int RW = DW + QB;
    localparam int CW = (MW > RW) ? MW : RW;
    localparam int NS = QB + 2;

    logic [0:NS-1] r_v;
    logic [0:NS]   en;
    logic [RW-1:0] r_rem [0:QB];
    logic [QB-1:0] r_q   [0:QB];
    logic [DW-1:0] r_den [0:QB];
    logic          r_sat [0:QB];
    t_div_tag      r_tag [0:QB+1];
    logic signed [QB-1:0] r_out;

    assign en[NS]  = i_ready;
    assign o_ready = en[0];

    for (genvar k = 0; k < NS; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // overflow check: quotient of 2^QB or more saturates anyway
    logic [CW-1:0] n_lim;
    assign n_lim = CW'(i_den) << QB;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rem[0] <= RW'(i_num);
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_sat[0] <= CW'(i_num) >= n_lim;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [RW-1:0] n_dsh;
        logic          n_ge;
        logic [RW-1:0] n_rem;
        logic [QB-1:0] n_q;

        always_comb begin
            n_dsh = RW'(r_den[k-1]) << (QB - k);
            n_ge  = r_rem[k-1] >= n_dsh;
            n_rem = n_ge ? r_rem[k-1] - n_dsh : r_rem[k-1];
            n_q   = r_q[k-1];
            n_q[QB-k] = n_ge;
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
                r_den[k] <= r_den[k-1];
                r_sat[k] <= r_sat[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // sign and saturation
    localparam logic [QB-1:0] MAXV = {1'b0, {(QB-1){1'b1}}};
    localparam logic [QB-1:0] MINV = {1'b1, {(QB-1){1'b0}}};
    logic [QB-1:0] n_out;
    logic [QB-1:0] w_q;

    assign w_q = r_q[QB];

    always_comb begin
        if (r_tag[QB].zero) begin
            n_out = '0;
        end else if (r_tag[QB].neg) begin
            n_out = (r_sat[QB] || (w_q > MINV)) ? MINV : QB'(-w_q);
        end else begin
            n_out = (r_sat[QB] || w_q[QB-1]) ? MAXV : w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_out        <= $signed(n_out);
            r_tag[QB+1]  <= r_tag[QB];
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_quot  = r_out;
    assign o_tag   = r_tag[QB+1];

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[QB] && !r_sat[QB] && !r_tag[QB].zero |-> r_rem[QB] < RW'(r_den[QB]))
        else $error("remainder not below divisor at last step");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tag.zero |-> o_quot == '0)
        else $error("flagged result is not zero");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("divider stalled with an empty slot");

endmodule

// ===== rtl/core/rotated_target_point_mapper.sv =====
// ----------------------------------------------------------------------------
// rotated_target_point_mapper
// Maps a patch centre given as chart fractions onto image pixels.
// ----------------------------------------------------------------------------
// Channels: i_pt takes one patch per transaction (rel_x, rel_x_mirror,
// rel_y, all Q0.16), o_px returns one pixel result per patch in the same
// order, i_cfg writes the eight setup registers by index (always ready;
// unknown indexes are dropped). Write registers only with no patch in flight.
// The path from input transaction to output valid runs through 8 arithmetic
// stages (the product chain of the y numerator sets that depth) and 27
// divider stages, one quotient bit a stage plus overflow check and
// saturation. A new patch can be taken every cycle unless a stall has filled every stage.
// When the receiver stalls, each stage holds its item and empty stages keep
// filling, so i_pt.ready falls only once every stage is occupied.
// Reset (synchronous, active low) empties the pipeline and loads corners 0,
// scale 1, width 1, height 1 and the upright orientation.
// ----------------------------------------------------------------------------
module rotated_target_point_mapper (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rtpm_pt_if.sink       i_pt,
    rtpm_px_if.source     o_px,
    rtpm_cfg_if.sink      i_cfg
);
    import rtpm_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.c0x   <= '0;
            r_cfg.c0y   <= '0;
            r_cfg.c1x   <= '0;
            r_cfg.c1y   <= '0;
            r_cfg.scale <= 9'd1;
            r_cfg.w     <= 16'd1;
            r_cfg.h     <= 16'd1;
            r_cfg.ud    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_C0X:   r_cfg.c0x   <= i_cfg.data;
                CFG_C0Y:   r_cfg.c0y   <= i_cfg.data;
                CFG_C1X:   r_cfg.c1x   <= i_cfg.data;
                CFG_C1Y:   r_cfg.c1y   <= i_cfg.data;
                CFG_SCALE: r_cfg.scale <= i_cfg.data[8:0];
                CFG_W:     r_cfg.w     <= i_cfg.data;
                CFG_H:     r_cfg.h     <= i_cfg.data;
                CFG_UD:    r_cfg.ud    <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    logic        w_fv, w_frdy;
    logic [MX_W-1:0] w_mx;
    logic [MY_W-1:0] w_my;
    logic [DY_W-1:0] w_deny;
    t_div_tag    w_tagx_in, w_tagy_in, w_tagx, w_tagy;
    logic        w_vx, w_vy, w_rdx, w_rdy;
    logic signed [OUT_W-1:0] w_qx, w_qy;

    rtpm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_pt.valid),
        .o_ready        (i_pt.ready),
        .i_rel_x        (i_pt.rel_x),
        .i_rel_x_mirror (i_pt.rel_x_mirror),
        .i_rel_y        (i_pt.rel_y),
        .o_valid        (w_fv),
        .i_ready        (w_frdy),
        .o_mx           (w_mx),
        .o_my           (w_my),
        .o_deny         (w_deny),
        .o_tag_x        (w_tagx_in),
        .o_tag_y        (w_tagy_in)
    );

    assign w_frdy = w_rdx && w_rdy;

    rtpm_div #(.MW(MX_W), .DW(DX_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .o_ready (w_rdx),
        .i_num   (w_mx),
        .i_den   (r_cfg.w),
        .i_tag   (w_tagx_in),
        .o_valid (w_vx),
        .i_ready (o_px.ready),
        .o_quot  (w_qx),
        .o_tag   (w_tagx)
    );

    rtpm_div #(.MW(MY_W), .DW(DY_W)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .o_ready (w_rdy),
        .i_num   (w_my),
        .i_den   (w_deny),
        .i_tag   (w_tagy_in),
        .o_valid (w_vy),
        .i_ready (o_px.ready),
        .o_quot  (w_qy),
        .o_tag   (w_tagy)
    );

    assign o_px.valid      = w_vx && w_vy;
    assign o_px.pixel_x    = w_qx;
    assign o_px.pixel_y    = w_qy;
    assign o_px.degenerate = w_tagx.zero && w_tagy.zero;

    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vx == w_vy && w_rdx == w_rdy)
        else $error("x and y dividers out of step");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_px.valid && o_px.degenerate |-> o_px.pixel_x == '0 && o_px.pixel_y == '0)
        else $error("degenerate result carries coordinates");

    a_flag_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_px.valid |-> w_tagx.zero == w_tagy.zero)
        else $error("degenerate flag differs between lanes");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rotated target point mapper: random and
// directed patches over several register settings, per-field comparison
// against an in-bench fixed point predictor, random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import rtpm_pkg::*;

    localparam int WDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [15:0] rx;
        logic [15:0] rxm;
        logic [15:0] ry;
    } t_patch;

    typedef struct {
        logic signed [OUT_W-1:0] px;
        logic signed [OUT_W-1:0] py;
        logic                    deg;
    } t_pixel;

    logic i_clk;
    logic i_rst_n;

    rtpm_pt_if  pt ();
    rtpm_px_if  px ();
    rtpm_cfg_if cfg ();

    rotated_target_point_mapper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt.sink),
        .o_px    (px.source),
        .i_cfg   (cfg.sink)
    );

    // shadow registers
    logic [15:0] r_c0x, r_c0y, r_c1x, r_c1y, r_w, r_h;
    logic [8:0]  r_scale;
    logic        r_ud;

    t_patch patch_q[$];
    t_pixel pixel_q[$];
    int     errors;
    int     send_idle_pct;
    int     recv_stall_pct;
    logic   hold_req;
    logic   hold_done;
    int     hold_left;
    int     quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic signed [OUT_W-1:0] sat_out(logic signed [127:0] q);
        if (q > 128'sd16777215)
            return 25'sd16777215;
        if (q < -128'sd16777216)
            return -25'sd16777216;
        return q[OUT_W-1:0];
    endfunction

    function automatic t_pixel map_patch(t_patch p);
        t_pixel r;
        logic signed [127:0] s, w, h, c0x, c0y, dx, dy, ax, sg, xx, yh, n, d2, nx, ny;
        s   = {119'd0, r_scale};
        w   = {112'd0, r_w};
        h   = {112'd0, r_h};
        c0x = $signed(r_c0x);
        c0y = $signed(r_c0y);
        dx  = ($signed({{112{r_c1x[15]}}, r_c1x}) - c0x) * s;
        dy  = ($signed({{112{r_c1y[15]}}, r_c1y}) - c0y) * s;
        if (dx == 0 || w == 0) begin
            r.px = '0;
            r.py = '0;
            r.deg = 1'b1;
            return r;
        end
        ax = (dx < 0) ? -dx : dx;
        sg = (dx < 0) ? -128'sd1 : 128'sd1;
        xx = {112'd0, (r_ud ? p.rxm : p.rx)};
        yh = {112'd0, p.ry};
        if (r_ud)
            yh = 128'sd65536 - yh;
        d2 = dx * dx + dy * dy;
        n  = xx * ax * w - sg * h * yh * dy;
        nx = n + s * c0x * 65536 * w;
        ny = n * dy * sg + yh * h * d2 + s * c0y * 65536 * w * ax;
        r.px = sat_out(nx / (65536 * w));
        r.py = sat_out(ny / (65536 * w * ax));
        r.deg = 1'b0;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt.valid <= 1'b0;
        end else if (!pt.valid || pt.ready) begin
            if (patch_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_patch p;
                p = patch_q.pop_front();
                pixel_q.insert(pixel_q.size(), map_patch(p));
                pt.valid        <= 1'b1;
                pt.rel_x        <= p.rx;
                pt.rel_x_mirror <= p.rxm;
                pt.rel_y        <= p.ry;
            end else begin
                pt.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            px.ready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else begin
            if (px.valid && px.ready) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d deg=%0b", $time,
                             px.pixel_x, px.pixel_y, px.degenerate);
                    errors++;
                end else begin
                    t_pixel e;
                    e = pixel_q.pop_front();
                    if (px.pixel_x !== e.px) begin
                        $display("%0t: pixel_x expected %0d actual %0d", $time, e.px,
                                 px.pixel_x);
                        errors++;
                    end
                    if (px.pixel_y !== e.py) begin
                        $display("%0t: pixel_y expected %0d actual %0d", $time, e.py,
                                 px.pixel_y);
                        errors++;
                    end
                    if (px.degenerate !== e.deg) begin
                        $display("%0t: degenerate expected %0b actual %0b", $time, e.deg,
                                 px.degenerate);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                px.ready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                px.ready  <= 1'b0;
            end else begin
                px.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (pt.valid && pt.ready) || (px.valid && px.ready) ||
            (cfg.valid && cfg.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [15:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge i_clk);
        while (!cfg.ready)
            @(posedge i_clk);
        case (idx)
            CFG_C0X:   r_c0x = val;
            CFG_C0Y:   r_c0y = val;
            CFG_C1X:   r_c1x = val;
            CFG_C1Y:   r_c1y = val;
            CFG_SCALE: r_scale = val[8:0];
            CFG_W:     r_w = val;
            CFG_H:     r_h = val;
            CFG_UD:    r_ud = val[0];
            default:   ;
        endcase
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_all(logic [15:0] c0x, logic [15:0] c0y, logic [15:0] c1x,
                           logic [15:0] c1y, logic [15:0] sc, logic [15:0] w,
                           logic [15:0] h, logic [15:0] ud);
        write_reg(CFG_C0X, c0x);
        write_reg(CFG_C0Y, c0y);
        write_reg(CFG_C1X, c1x);
        write_reg(CFG_C1Y, c1y);
        write_reg(CFG_SCALE, sc);
        write_reg(CFG_W, w);
        write_reg(CFG_H, h);
        write_reg(CFG_UD, ud);
        // unknown index must be dropped
        write_reg(CIDX_W'($urandom_range(15, 8)), 16'($urandom));
    endtask

    task automatic add_patch(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        t_patch p;
        p.rx = a;
        p.rxm = b;
        p.ry = c;
        patch_q.insert(patch_q.size(), p);
    endtask

    task automatic add_random(int count);
        repeat (count)
            add_patch(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        while (patch_q.size() > 0 || pixel_q.size() > 0)
            @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic idle_mode(int m);
        case (m % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
    endtask

    initial begin
        errors = 0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        r_c0x = '0; r_c0y = '0; r_c1x = '0; r_c1y = '0;
        r_scale = 9'd1; r_w = 16'd1; r_h = 16'd1; r_ud = 1'b0;
        pt.valid = 1'b0; pt.rel_x = '0; pt.rel_x_mirror = '0; pt.rel_y = '0;
        px.ready = 1'b0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: equal corners leave a zero edge vector, so results are degenerate
        add_patch(16'hffff, 16'h0000, 16'h8000);
        add_random(4);
        drain();

        // directed extremes, upright
        set_all(16'h0000, 16'h0000, 16'h0064, 16'h0014, 16'd4, 16'd300, 16'd200, 16'd0);
        add_patch(16'h0000, 16'h0000, 16'h0000);
        add_patch(16'hffff, 16'hffff, 16'hffff);
        add_patch(16'hffff, 16'h0000, 16'h0000);
        add_patch(16'h0000, 16'hffff, 16'hffff);
        add_patch(16'h8000, 16'h5555, 16'haaaa);
        drain();
        // upside down, negative dx, full range corners and largest scale
        set_all(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h01ff, 16'd1, 16'hffff, 16'd1);
        add_patch(16'h0000, 16'hffff, 16'h0000);
        add_patch(16'hffff, 16'h0000, 16'hffff);
        add_patch(16'h1234, 16'hedcb, 16'h8000);
        drain();
        // zero width
        set_all(16'h0010, 16'h0000, 16'h0100, 16'h0040, 16'd2, 16'd0, 16'd100, 16'd0);
        add_patch(16'hffff, 16'hffff, 16'hffff);
        add_patch(16'h0000, 16'h0000, 16'h0000);
        drain();
        // zero scale (upper data bits dropped) and zero height
        set_all(16'h0010, 16'h0000, 16'h0100, 16'h0040, 16'hfe00, 16'd50, 16'd0, 16'hfffe);
        add_patch(16'h4000, 16'h4000, 16'h4000);
        drain();

        // random phases over a range of settings
        for (int ph = 0; ph < 12; ph++) begin
            idle_mode(ph);
            case (ph % 4)
                0: set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                1: set_all(16'($urandom_range(2000)), 16'($urandom_range(2000)),
                           16'($urandom_range(4000, 2100)), 16'($urandom_range(2500)),
                           16'($urandom_range(8, 1)), 16'($urandom_range(1000, 10)),
                           16'($urandom_range(1000, 10)), 16'($urandom_range(1)));
                2: set_all(16'($urandom_range(3000)), 16'($urandom_range(3000)),
                           16'($urandom_range(3000)), 16'($urandom_range(3000)),
                           16'($urandom_range(511)), 16'($urandom_range(3)),
                           16'($urandom_range(65535, 65000)), 16'($urandom_range(1)));
                default: set_all(16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                                 16'($urandom_range(511, 256)), 16'hffff, 16'hffff,
                                 16'($urandom_range(1)));
            endcase
            if (ph == 4)
                hold_req = 1'b1;
            add_random(157);
            drain();
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
